// ===== src/ealt_pkg.sv =====
// ----------------------------------------------------------------------------
// Euler angles to light direction: shared constants
// Fixed-point constants for the angle reduction, the degree to radian scale,
// the sine/cosine series and the pipeline latencies of the datapath.
// ----------------------------------------------------------------------------
package ealt_pkg;

  // One in unsigned Q30, the format of every sine/cosine term.
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  // Angle reduction works on the whole-degree part of the Q16.16 angle.
  // The bias lifts the signed 16-bit degree count to a positive value that
  // is a multiple of 360 away from it (36000 = 100 turns).
  localparam logic [16:0] DEG_BIAS      = 17'd3232;   // 36000 - 32768
  localparam logic [15:0] RECIP360      = 16'd46603;  // floor(2^24 / 360)
  localparam int          RECIP360_SHR  = 24;
  localparam logic [16:0] TURN_DEG      = 17'd360;
  localparam logic [8:0]  QUARTER_DEG   = 9'd90;

  // pi/180 * 2^40, split in two halves so that each product stays narrow.
  localparam logic [34:0] DEG2RAD_K     = 35'd19190098069;
  localparam int          DEG2RAD_SPLIT = 18;
  localparam logic [16:0] DEG2RAD_KH    = 17'(DEG2RAD_K >> DEG2RAD_SPLIT);
  localparam logic [17:0] DEG2RAD_KL    = DEG2RAD_K[17:0];

  // Series terms: each Horner step divides by one of these.
  localparam int N_TERMS = 5;
  localparam int unsigned SIN_DEN [N_TERMS] = '{110, 72, 42, 20, 6};
  localparam int unsigned COS_DEN [N_TERMS] = '{132, 90, 56, 30, 12};

  // Pipeline depths.
  localparam int HORNER_LAT = 3;
  localparam int SC_LAT     = 8 + N_TERMS * HORNER_LAT;
  localparam int MULQ_LAT   = 2;

endpackage

// ===== src/ealt_horner_step.sv =====
// ----------------------------------------------------------------------------
// Horner step
// One series step t' = 1 - ((x2 * t) >> 30) / DEN in three register stages:
// product, reciprocal multiply, and quotient correction.
// ----------------------------------------------------------------------------
module ealt_horner_step #(
  parameter int unsigned DEN = 6
) (
  input  logic        clk_i,
  input  logic [31:0] x2_i,
  input  logic [30:0] t_i,
  output logic [30:0] t_o
);
  import ealt_pkg::*;

  // Reciprocal scaled so that it fills 32 bits; the estimate is then low
  // by at most one.
  localparam int          SHIFT = 31 + $clog2(DEN);
  localparam logic [31:0] RECIP = 32'((64'd1 << SHIFT) / DEN);
  localparam logic [31:0] DEN_W = 32'(DEN);

  logic [62:0] prod;
  logic [31:0] p_q;
  logic [63:0] pm_q;
  logic [31:0] pb_q;
  logic [31:0] q_est;
  logic [31:0] q_den;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [30:0] t_q;

  // First stage: the Q30 product x2 * t.
  assign prod = 63'(x2_i) * 63'(t_i);

  always_ff @(posedge clk_i) begin
    p_q <= prod[61:30];
  end

  // Second stage: multiply by the reciprocal of the divisor.
  always_ff @(posedge clk_i) begin
    pm_q <= 64'(p_q) * 64'(RECIP);
    pb_q <= p_q;
  end

  // Third stage: fix the quotient estimate and subtract from one.
  always_comb begin
    q_est = 32'(pm_q >> SHIFT);
    q_den = q_est * DEN_W;
    rem   = pb_q - q_den;
    quo   = (rem >= DEN_W) ? q_est + 32'd1 : q_est;
  end

  always_ff @(posedge clk_i) begin
    t_q <= Q30_ONE - quo[30:0];
  end

  assign t_o = t_q;

endmodule

// ===== src/ealt_sincos.sv =====
// ----------------------------------------------------------------------------
// Sine and cosine of one angle
// Reduces a Q16.16 degree angle to a quadrant and a first-quadrant remainder,
// converts to Q30 radians and evaluates both series in parallel Horner chains.
// Results are signed Q30.
// ----------------------------------------------------------------------------
module ealt_sincos (
  input  logic               clk_i,
  input  logic signed [31:0] angle_i,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);
  import ealt_pkg::*;

  localparam int HD = N_TERMS * HORNER_LAT;

  typedef enum logic [1:0] {
    QUAD_I, QUAD_II, QUAD_III, QUAD_IV
  } quad_e;

  logic [16:0] u_d;
  logic [32:0] qq_prod;
  logic [16:0] u_q;
  logic [15:0] l1_q;
  logic [7:0]  qq_q;
  logic [16:0] rem;
  logic [8:0]  d_d;
  logic [8:0]  d_q;
  logic [15:0] l2_q;
  quad_e       quad_d;
  logic [8:0]  rd_full;
  logic [22:0] r_q;
  logic [40:0] ppl_q;
  logic [39:0] pph_q;
  logic [58:0] rad_sum;
  logic [61:0] x_sq;
  logic [30:0] x_dly_q [HD+2];
  logic [31:0] x2_dly_q [HD+1];
  quad_e       quad_dly_q [HD+4];
  logic [30:0] ts_chain [N_TERMS+1];
  logic [30:0] tc_chain [N_TERMS+1];
  logic [61:0] s_prod;
  logic [62:0] c_prod;
  logic [30:0] s_d;
  logic [30:0] s_q;
  logic [30:0] uc_q;
  quad_e       quad_q;
  logic [30:0] c_d;
  logic signed [31:0] s_pos;
  logic signed [31:0] c_pos;
  logic signed [31:0] sin_q;
  logic signed [31:0] cos_q;

  // Whole degrees biased positive, then a reciprocal estimate of u / 360.
  assign u_d     = {1'b0, ~angle_i[31], angle_i[30:16]} + DEG_BIAS;
  assign qq_prod = 33'(u_d) * 33'(RECIP360);

  always_ff @(posedge clk_i) begin
    u_q  <= u_d;
    l1_q <= angle_i[15:0];
    qq_q <= qq_prod[RECIP360_SHR +: 8];
  end

  // Remainder modulo 360; the estimate is low by at most one turn.
  always_comb begin
    rem = u_q - 17'(qq_q) * TURN_DEG;
    d_d = (rem >= TURN_DEG) ? 9'(rem - TURN_DEG) : rem[8:0];
  end

  always_ff @(posedge clk_i) begin
    d_q  <= d_d;
    l2_q <= l1_q;
  end

  // Quadrant and remainder within the quadrant, back in unsigned Q7.16.
  always_comb begin
    priority if (d_q >= 9'(3 * QUARTER_DEG)) begin
      quad_d  = QUAD_IV;
      rd_full = d_q - 9'(3 * QUARTER_DEG);
    end else if (d_q >= 9'(2 * QUARTER_DEG)) begin
      quad_d  = QUAD_III;
      rd_full = d_q - 9'(2 * QUARTER_DEG);
    end else if (d_q >= QUARTER_DEG) begin
      quad_d  = QUAD_II;
      rd_full = d_q - QUARTER_DEG;
    end else begin
      quad_d  = QUAD_I;
      rd_full = d_q;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= {rd_full[6:0], l2_q};
  end

  // Degree to radian scale as two partial products.
  always_ff @(posedge clk_i) begin
    ppl_q <= 41'(r_q) * 41'(DEG2RAD_KL);
    pph_q <= 40'(r_q) * 40'(DEG2RAD_KH);
  end

  // Sum the partial products and round to Q30 radians.
  assign rad_sum = (59'(pph_q) << DEG2RAD_SPLIT) + 59'(ppl_q) + (59'd1 << 25);

  // Square of the angle in Q30.
  assign x_sq = 62'(x_dly_q[0]) * 62'(x_dly_q[0]);

  // Delay lines that keep x, x2 and the quadrant next to the series terms.
  // Their first entries take the quadrant, the Q30 radians and the square.
  always_ff @(posedge clk_i) begin
    quad_dly_q[0] <= quad_d;
    x_dly_q[0]    <= rad_sum[56:26];
    x2_dly_q[0]   <= x_sq[61:30];
    for (int k = 1; k < HD + 2; k++) begin
      x_dly_q[k] <= x_dly_q[k-1];
    end
    for (int k = 1; k < HD + 1; k++) begin
      x2_dly_q[k] <= x2_dly_q[k-1];
    end
    for (int k = 1; k < HD + 4; k++) begin
      quad_dly_q[k] <= quad_dly_q[k-1];
    end
  end

  // Sine and cosine series, one Horner step per term.
  assign ts_chain[0] = Q30_ONE;
  assign tc_chain[0] = Q30_ONE;

  for (genvar i = 0; i < N_TERMS; i++) begin : g_term
    ealt_horner_step #(
      .DEN (SIN_DEN[i])
    ) u_sin_step (
      .clk_i (clk_i),
      .x2_i  (x2_dly_q[i*HORNER_LAT]),
      .t_i   (ts_chain[i]),
      .t_o   (ts_chain[i+1])
    );

    ealt_horner_step #(
      .DEN (COS_DEN[i])
    ) u_cos_step (
      .clk_i (clk_i),
      .x2_i  (x2_dly_q[i*HORNER_LAT]),
      .t_i   (tc_chain[i]),
      .t_o   (tc_chain[i+1])
    );
  end

  // Final products: sine capped at one, cosine half term.
  always_comb begin
    s_prod = 62'(x_dly_q[HD+1]) * 62'(ts_chain[N_TERMS]);
    c_prod = 63'(x2_dly_q[HD]) * 63'(tc_chain[N_TERMS]);
    s_d    = (s_prod[60:30] > Q30_ONE) ? Q30_ONE : s_prod[60:30];
  end

  always_ff @(posedge clk_i) begin
    s_q    <= s_d;
    uc_q   <= c_prod[61:31];
    quad_q <= quad_dly_q[HD+3];
  end

  // Cosine floored at zero, then the quadrant sets signs and swaps.
  always_comb begin
    c_d   = (uc_q >= Q30_ONE) ? 31'd0 : Q30_ONE - uc_q;
    s_pos = $signed({1'b0, s_q});
    c_pos = $signed({1'b0, c_d});
  end

  always_ff @(posedge clk_i) begin
    unique case (quad_q)
      QUAD_I: begin
        sin_q <= s_pos;
        cos_q <= c_pos;
      end
      QUAD_II: begin
        sin_q <= c_pos;
        cos_q <= -s_pos;
      end
      QUAD_III: begin
        sin_q <= -s_pos;
        cos_q <= -c_pos;
      end
      QUAD_IV: begin
        sin_q <= -c_pos;
        cos_q <= s_pos;
      end
      default: begin
        sin_q <= s_pos;
        cos_q <= c_pos;
      end
    endcase
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

// ===== src/ealt_mulq.sv =====
// ----------------------------------------------------------------------------
// Signed Q30 multiplier
// Multiplies magnitudes, rounds half away from zero back to Q30 and applies
// the sign. Two register stages.
// ----------------------------------------------------------------------------
module ealt_mulq (
  input  logic               clk_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [31:0] p_o
);
  import ealt_pkg::*;

  logic [30:0] mag_a;
  logic [30:0] mag_b;
  logic [61:0] prod;
  logic [60:0] prod_q;
  logic        neg_q;
  logic [60:0] rnd;
  logic [30:0] mag_p;
  logic signed [31:0] p_q;

  // Magnitudes and their product.
  always_comb begin
    mag_a = a_i[31] ? 31'(-a_i) : a_i[30:0];
    mag_b = b_i[31] ? 31'(-b_i) : b_i[30:0];
    prod  = 62'(mag_a) * 62'(mag_b);
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod[60:0];
    neg_q  <= a_i[31] ^ b_i[31];
  end

  // Round to Q30 and restore the sign.
  always_comb begin
    rnd   = prod_q + (61'd1 << 29);
    mag_p = rnd[60:30];
  end

  always_ff @(posedge clk_i) begin
    p_q <= neg_q ? -$signed({1'b0, mag_p}) : $signed({1'b0, mag_p});
  end

  assign p_o = p_q;

endmodule

// ===== src/euler_angles_to_light_direction_core.sv =====
// ----------------------------------------------------------------------------
// Euler angles to light direction
// Rotates the vector (0,-1,0) by Rx*Ry*Rz built from three Q16.16 degree
// angles and returns the direction as signed fixed point, saturated to +-1.
//
//   Channel   Ports                               Dir   Handshake
//   request   angle_x_i, angle_y_i, angle_z_i     in    start_i, busy_o
//   result    dir_x_o, dir_y_o, dir_z_o           out   done_o (strobe)
//
// One request is taken every cycle; busy_o stays low.
// The pipeline depth is set mostly by the five Horner steps of the
// sine/cosine series at three stages each.
// Reset clears only the valid pipeline; data registers are not reset.
// The result is on the ports for one cycle with done_o; nothing stalls.
// ----------------------------------------------------------------------------
module euler_angles_to_light_direction_core #(
  parameter int DIR_FRAC_BITS = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] angle_x_i,
  input  logic signed [31:0] angle_y_i,
  input  logic signed [31:0] angle_z_i,
  output logic               done_o,
  output logic signed [15:0] dir_x_o,
  output logic signed [15:0] dir_y_o,
  output logic signed [15:0] dir_z_o
);
  import ealt_pkg::*;

  localparam int          TOTAL_LAT = SC_LAT + 2 * MULQ_LAT + 2;
  localparam int          SH        = 30 - DIR_FRAC_BITS;
  localparam logic [33:0] RND       = (SH > 0) ? (34'd1 << ((SH > 0) ? SH - 1 : 0)) : 34'd0;
  localparam logic [33:0] LIM       = 34'd1 << DIR_FRAC_BITS;

  logic [TOTAL_LAT-1:0] valid_q;
  logic signed [31:0] sx;
  logic signed [31:0] cx;
  logic signed [31:0] sy;
  logic signed [31:0] cy;
  logic signed [31:0] sz;
  logic signed [31:0] cz;
  logic signed [31:0] dx;
  logic signed [31:0] sxsy;
  logic signed [31:0] cxcz;
  logic signed [31:0] sxcz;
  logic signed [31:0] cxsy;
  logic signed [31:0] sxsysz;
  logic signed [31:0] cxsysz;
  logic signed [31:0] sz_dly_q   [MULQ_LAT];
  logic signed [31:0] dx_dly_q   [MULQ_LAT];
  logic signed [31:0] cxcz_dly_q [MULQ_LAT];
  logic signed [31:0] sxcz_dly_q [MULQ_LAT];
  logic signed [32:0] sum_x_q;
  logic signed [32:0] sum_y_q;
  logic signed [32:0] sum_z_q;
  logic [15:0] dir_x_q;
  logic [15:0] dir_y_q;
  logic [15:0] dir_z_q;

  // Round Q30 to the output scale, saturate and keep the low 16 bits.
  function automatic logic [15:0] to_out(input logic signed [32:0] v);
    logic signed [33:0] vx;
    logic [33:0] mag;
    logic [33:0] rmag;
    logic [33:0] res;
    vx   = {v[32], v};
    mag  = vx[33] ? 34'(-vx) : 34'(vx);
    rmag = (mag + RND) >> SH;
    if (rmag > LIM) begin
      rmag = LIM;
    end
    res = vx[33] ? 34'd0 - rmag : rmag;
    return res[15:0];
  endfunction

  // The pipeline never stalls, so a request is always taken.
  assign busy_o = 1'b0;

  // Valid bits that follow each request down the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[TOTAL_LAT-2:0], start_i & ~busy_o};
    end
  end

  // Sine and cosine of each angle.
  ealt_sincos u_sc_x (.clk_i(clk_i), .angle_i(angle_x_i), .sin_o(sx), .cos_o(cx));
  ealt_sincos u_sc_y (.clk_i(clk_i), .angle_i(angle_y_i), .sin_o(sy), .cos_o(cy));
  ealt_sincos u_sc_z (.clk_i(clk_i), .angle_i(angle_z_i), .sin_o(sz), .cos_o(cz));

  // First level of products.
  ealt_mulq u_m_dx   (.clk_i(clk_i), .a_i(cy), .b_i(sz), .p_o(dx));
  ealt_mulq u_m_sxsy (.clk_i(clk_i), .a_i(sx), .b_i(sy), .p_o(sxsy));
  ealt_mulq u_m_cxcz (.clk_i(clk_i), .a_i(cx), .b_i(cz), .p_o(cxcz));
  ealt_mulq u_m_sxcz (.clk_i(clk_i), .a_i(sx), .b_i(cz), .p_o(sxcz));
  ealt_mulq u_m_cxsy (.clk_i(clk_i), .a_i(cx), .b_i(sy), .p_o(cxsy));

  // Keep sz and the finished first-level terms aligned with the second level.
  always_ff @(posedge clk_i) begin
    sz_dly_q[0]   <= sz;
    dx_dly_q[0]   <= dx;
    cxcz_dly_q[0] <= cxcz;
    sxcz_dly_q[0] <= sxcz;
    for (int k = 1; k < MULQ_LAT; k++) begin
      sz_dly_q[k]   <= sz_dly_q[k-1];
      dx_dly_q[k]   <= dx_dly_q[k-1];
      cxcz_dly_q[k] <= cxcz_dly_q[k-1];
      sxcz_dly_q[k] <= sxcz_dly_q[k-1];
    end
  end

  // Second level of products with sz.
  ealt_mulq u_m_sxsysz (
    .clk_i (clk_i),
    .a_i   (sxsy),
    .b_i   (sz_dly_q[MULQ_LAT-1]),
    .p_o   (sxsysz)
  );

  ealt_mulq u_m_cxsysz (
    .clk_i (clk_i),
    .a_i   (cxsy),
    .b_i   (sz_dly_q[MULQ_LAT-1]),
    .p_o   (cxsysz)
  );

  // Exact sums of the rotated components.
  always_ff @(posedge clk_i) begin
    sum_x_q <= 33'(dx_dly_q[MULQ_LAT-1]);
    sum_y_q <= 33'(sxsysz) - 33'(cxcz_dly_q[MULQ_LAT-1]);
    sum_z_q <= -33'(sxcz_dly_q[MULQ_LAT-1]) - 33'(cxsysz);
  end

  // Output scaling and saturation.
  always_ff @(posedge clk_i) begin
    dir_x_q <= to_out(sum_x_q);
    dir_y_q <= to_out(sum_y_q);
    dir_z_q <= to_out(sum_z_q);
  end

  assign done_o  = valid_q[TOTAL_LAT-1];
  assign dir_x_o = $signed(dir_x_q);
  assign dir_y_o = $signed(dir_y_q);
  assign dir_z_o = $signed(dir_z_q);

endmodule
